@@ hw/rtl/uv_sphere_mesh_generator_assert.svh @@
// assertion macros for the sphere mesh generator
`ifndef UV_SPHERE_MESH_GENERATOR_ASSERT_SVH
`define UV_SPHERE_MESH_GENERATOR_ASSERT_SVH

// same-cycle implication under active-low reset
`define UVSMG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under active-low reset
`define UVSMG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/uvsmg_pkg.sv @@
package uvsmg_pkg;

    localparam int IDX_W    = 7;
    localparam int CNT_W    = 7;
    localparam int CORNER_W = 13;
    localparam int FIX_W    = 16;
    localparam int PHASE_W  = 32;
    localparam int QUO_W    = PHASE_W + 1;
    localparam int DIV_W    = IDX_W + PHASE_W;
    localparam int DIV_BPS  = 4;
    localparam int DIV_ST   = (DIV_W + DIV_BPS - 1) / DIV_BPS;
    localparam int CW       = 34;
    localparam int ATAN_N   = 24;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [30:0]          HALF_PI_Q30 = 31'd1686629713;

    localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127
    };

    localparam logic REG_SECTOR = 1'b0;
    localparam logic REG_STACK  = 1'b1;

    // per-request info that rides along the whole pipeline
    typedef struct packed {
        logic                is_tri;
        logic                bad;
        logic                first;
        logic                second;
        logic [CORNER_W-1:0] k1;
        logic [CORNER_W-1:0] k2;
        logic [FIX_W-1:0]    tex_u;
        logic [FIX_W-1:0]    tex_v;
    } side_t;

    typedef struct packed {
        logic [FIX_W-1:0]    pos_x;
        logic [FIX_W-1:0]    pos_y;
        logic [FIX_W-1:0]    pos_z;
        logic [FIX_W-1:0]    norm_x;
        logic [FIX_W-1:0]    norm_y;
        logic [FIX_W-1:0]    norm_z;
        logic [FIX_W-1:0]    tex_u;
        logic [FIX_W-1:0]    tex_v;
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
    } result_t;

endpackage

@@ hw/rtl/uv_sphere_mesh_generator.sv @@
// channel   | dir | handshake          | payload
// s_        | in  | s_tvalid/s_tready  | tdata: stack_index, sector_index; tuser: req_type
// m_        | out | m_tvalid/m_tready  | tdata: pos, norm, tex, corners; tlast: last
// apb       | in  | psel/penable/pready| reg 0 sector_count at 0x0, reg 1 stack_count at 0x4
//
// one request enters per cycle while s_tready is high; a vertex or a one-triangle
// request leaves one beat; a two-triangle cell leaves two, holding the input for the second
// stages: entry, DIV_ST (10) divider, phase, z, CORDIC_STAGES CORDIC, quadrant, product, output
// throughput is set by the single output register, one beat per cycle while m_tready is high
// aresetn is synchronous active low; it clears valid bits and restores both counts to 20
// a stall on m_tready freezes every stage at once, so nothing is lost or repeated

`include "uv_sphere_mesh_generator_assert.svh"

module uv_sphere_mesh_generator #(
    parameter int MAX_SECTORS   = 64,
    parameter int MAX_STACKS    = 64,
    parameter int CORDIC_STAGES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // stack_index[6:0], sector_index[13:7], zero pad
    input  logic [0:0]   s_tuser,   // req_type[0]
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                    // tex_u, tex_v (16 each), corner_a/b/c (13 each), pad
    output logic         m_tlast,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IDX_W  = uvsmg_pkg::IDX_W;
    localparam int CNT_W  = uvsmg_pkg::CNT_W;
    localparam int CRN_W  = uvsmg_pkg::CORNER_W;
    localparam int FIX_W  = uvsmg_pkg::FIX_W;
    localparam int QUO_W  = uvsmg_pkg::QUO_W;
    localparam int DIV_W  = uvsmg_pkg::DIV_W;
    localparam int BPS    = uvsmg_pkg::DIV_BPS;
    localparam int DIV_ST = uvsmg_pkg::DIV_ST;
    localparam int CW     = uvsmg_pkg::CW;
    localparam int CS     = CORDIC_STAGES;
    // stage positions in the valid/side chain
    localparam int SP1    = DIV_ST + 1;
    localparam int SP2    = DIV_ST + 2;
    localparam int SQ     = DIV_ST + 3 + CS;
    localparam int SM     = SQ + 1;
    localparam int TOT    = SM + 1;

    // ---------------- configuration registers ----------------
    logic [CNT_W-1:0] sector_reg, stack_reg;
    logic [CNT_W-1:0] wval;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign wval   = pwdata[CNT_W-1:0];
    assign prdata = {25'd0, (paddr[2] == uvsmg_pkg::REG_STACK) ? stack_reg : sector_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_reg <= 7'd20;
            stack_reg  <= 7'd20;
        end else if (cfg_wr) begin
            if (paddr[2] == uvsmg_pkg::REG_SECTOR) begin
                if (wval < 7'd3)
                    sector_reg <= 7'd3;
                else if ({1'b0, wval} > 8'(MAX_SECTORS))
                    sector_reg <= 7'(MAX_SECTORS);
                else
                    sector_reg <= wval;
            end else begin
                if (wval < 7'd2)
                    stack_reg <= 7'd2;
                else if ({1'b0, wval} > 8'(MAX_STACKS))
                    stack_reg <= 7'(MAX_STACKS);
                else
                    stack_reg <= wval;
            end
        end
    end

    // ---------------- pipeline control ----------------
    logic                 en;
    logic                 v_reg    [TOT];
    uvsmg_pkg::side_t     side_reg [TOT];
    logic                 m_valid_reg, has2_reg, m_last_reg;
    uvsmg_pkg::result_t   m_data_reg;
    logic [CRN_W-1:0]     sec_a_reg, sec_b_reg, sec_c_reg;

    // whole chain moves when the output register can take a new item
    assign en       = ~m_valid_reg | (m_tready & ~has2_reg);
    assign s_tready = en;

    // ---------------- entry stage ----------------
    logic [IDX_W-1:0]  in_i, in_j;
    logic              in_tri;
    logic [14:0]       k1_full;
    logic [CRN_W-1:0]  k1_w, k2_w;
    uvsmg_pkg::side_t  side_in;
    logic [IDX_W-1:0]  ei_reg, ej_reg;

    assign in_i   = s_tdata[6:0];
    assign in_j   = s_tdata[13:7];
    assign in_tri = s_tuser[0];

    always_comb begin
        k1_full = 15'(in_i * ({1'b0, sector_reg} + 8'd1)) + 15'(in_j);
        k1_w    = k1_full[CRN_W-1:0];
        k2_w    = k1_w + CRN_W'(sector_reg) + 13'd1;
        side_in = '0;
        side_in.is_tri = in_tri;
        side_in.bad    = in_tri ? ((in_i >= stack_reg) || (in_j >= sector_reg))
                                : ((in_i > stack_reg) || (in_j > sector_reg));
        side_in.first  = (in_i != 7'd0);
        side_in.second = (in_i != (stack_reg - 7'd1));
        side_in.k1     = k1_w;
        side_in.k2     = k2_w;
    end

    // ---------------- dividers: floor(x * 2^32 / n), radix 2, BPS bits a stage ----------------
    logic [CNT_W-1:0] dse_rem_reg [DIV_ST], dst_rem_reg [DIV_ST];
    logic [QUO_W-1:0] dse_q_reg   [DIV_ST], dst_q_reg   [DIV_ST];
    logic [IDX_W-1:0] dj_reg      [DIV_ST], di_reg      [DIV_ST];
    logic [CNT_W-1:0] dse_rem_next[DIV_ST], dst_rem_next[DIV_ST];
    logic [QUO_W-1:0] dse_q_next  [DIV_ST], dst_q_next  [DIV_ST];

    function automatic logic [7:0] div_step(input logic [6:0] rem, input logic dbit,
                                            input logic [6:0] den);
        logic [7:0] r2;
        r2 = {rem, dbit};
        if (r2 >= {1'b0, den})
            div_step = {1'b1, 7'(r2 - {1'b0, den})};
        else
            div_step = {1'b0, r2[6:0]};
    endfunction

    always_comb begin
        logic [CNT_W-1:0] r_se, r_st;
        logic [QUO_W-1:0] q_se, q_st;
        logic [IDX_W-1:0] x_se, x_st;
        logic [7:0]       st_se, st_st;
        logic             b_se, b_st;
        int               g;
        for (int k = 0; k < DIV_ST; k++) begin
            if (k == 0) begin
                r_se = '0;
                r_st = '0;
                q_se = '0;
                q_st = '0;
                x_se = ej_reg;
                x_st = ei_reg;
            end else begin
                r_se = dse_rem_reg[k-1];
                r_st = dst_rem_reg[k-1];
                q_se = dse_q_reg[k-1];
                q_st = dst_q_reg[k-1];
                x_se = dj_reg[k-1];
                x_st = di_reg[k-1];
            end
            for (int t = 0; t < BPS; t++) begin
                g = k * BPS + t;
                if (g < DIV_W) begin
                    b_se = 1'b0;
                    b_st = 1'b0;
                    if (g < IDX_W) begin
                        b_se = x_se[IDX_W-1-g];
                        b_st = x_st[IDX_W-1-g];
                    end
                    st_se = div_step(r_se, b_se, sector_reg);
                    st_st = div_step(r_st, b_st, stack_reg);
                    r_se  = st_se[6:0];
                    r_st  = st_st[6:0];
                    q_se  = {q_se[QUO_W-2:0], st_se[7]};
                    q_st  = {q_st[QUO_W-2:0], st_st[7]};
                end
            end
            dse_rem_next[k] = r_se;
            dst_rem_next[k] = r_st;
            dse_q_next[k]   = q_se;
            dst_q_next[k]   = q_st;
        end
    end

    // ---------------- phase split into quadrant and residual ----------------
    // unit 0 is the stack angle, unit 1 the sector angle
    function automatic logic [32:0] phase_split(input logic [31:0] phase);
        logic [31:0] qsum, ru, mg;
        logic [1:0]  q;
        qsum = phase + 32'h2000_0000;
        q    = qsum[31:30];
        ru   = phase - {q, 30'd0};
        mg   = ru[31] ? (32'd0 - ru) : ru;
        phase_split = {q, ru[31], mg[29:0]};
    endfunction

    logic [31:0] ph_se, ph_st;
    logic [32:0] sp_se, sp_st;
    logic [1:0]  p1_q_reg [2];
    logic        p1_neg_reg [2];
    logic [29:0] p1_mag_reg [2];
    logic [1:0]  p2_q_reg [2];
    logic        p2_neg_reg [2];
    logic [30:0] p2_z_reg [2];
    logic [60:0] zprod [2];

    assign ph_se = dse_q_reg[DIV_ST-1][31:0];
    assign ph_st = 32'h4000_0000 - dst_q_reg[DIV_ST-1][32:1];
    assign sp_se = phase_split(ph_se);
    assign sp_st = phase_split(ph_st);
    assign zprod[0] = p1_mag_reg[0] * uvsmg_pkg::HALF_PI_Q30;
    assign zprod[1] = p1_mag_reg[1] * uvsmg_pkg::HALF_PI_Q30;

    // ---------------- CORDIC, one micro-rotation per stage ----------------
    logic signed [CW-1:0] cx_reg [CS][2], cy_reg [CS][2], cz_reg [CS][2];
    logic [1:0]           cq_reg [CS][2];
    logic signed [CW-1:0] cx_next[CS][2], cy_next[CS][2], cz_next[CS][2];
    logic [1:0]           cq_next[CS][2];

    always_comb begin
        logic signed [CW-1:0] xi, yi, zi, at;
        logic [1:0]           qi;
        for (int u = 0; u < 2; u++) begin
            for (int k = 0; k < CS; k++) begin
                if (k == 0) begin
                    xi = uvsmg_pkg::CORDIC_GAIN;
                    yi = '0;
                    zi = p2_neg_reg[u] ? -$signed({3'b000, p2_z_reg[u]})
                                       :  $signed({3'b000, p2_z_reg[u]});
                    qi = p2_q_reg[u];
                end else begin
                    xi = cx_reg[k-1][u];
                    yi = cy_reg[k-1][u];
                    zi = cz_reg[k-1][u];
                    qi = cq_reg[k-1][u];
                end
                at = $signed({2'b00, uvsmg_pkg::ATAN_Q30[k]});
                if (!zi[CW-1]) begin
                    cx_next[k][u] = xi - (yi >>> k);
                    cy_next[k][u] = yi + (xi >>> k);
                    cz_next[k][u] = zi - at;
                end else begin
                    cx_next[k][u] = xi + (yi >>> k);
                    cy_next[k][u] = yi - (xi >>> k);
                    cz_next[k][u] = zi + at;
                end
                cq_next[k][u] = qi;
            end
        end
    end

    // ---------------- quadrant rotation, products, rounding ----------------
    logic signed [31:0]   qc_reg [2], qs_reg [2];
    logic signed [31:0]   qc_next [2], qs_next [2];
    logic signed [63:0]   pxp_reg, pyp_reg;
    logic signed [15:0]   pz_reg;
    logic signed [31:0]   pz_sum;

    always_comb begin
        logic signed [CW-1:0] xf, yf;
        for (int u = 0; u < 2; u++) begin
            xf = cx_reg[CS-1][u];
            yf = cy_reg[CS-1][u];
            unique case (cq_reg[CS-1][u])
                2'd0: begin qc_next[u] = 32'(xf);  qs_next[u] = 32'(yf);  end
                2'd1: begin qc_next[u] = 32'(-yf); qs_next[u] = 32'(xf);  end
                2'd2: begin qc_next[u] = 32'(-xf); qs_next[u] = 32'(-yf); end
                default: begin qc_next[u] = 32'(yf); qs_next[u] = 32'(-xf); end
            endcase
        end
    end

    assign pz_sum = qs_reg[0] + 32'sd32768;

    // ---------------- output assembly ----------------
    uvsmg_pkg::side_t     sd;
    uvsmg_pkg::result_t   res0;
    uvsmg_pkg::result_t   res1;
    logic                 res0_last;
    logic signed [63:0]   sx, sy;
    logic signed [17:0]   px18, py18;

    function automatic logic [15:0] sat_dbl18(input logic signed [17:0] v);
        logic signed [18:0] d;
        d = {v, 1'b0};
        if (d > 19'sd32767)
            sat_dbl18 = 16'h7fff;
        else if (d < -19'sd32768)
            sat_dbl18 = 16'h8000;
        else
            sat_dbl18 = d[15:0];
    endfunction

    assign sd   = side_reg[SM];
    assign sx   = pxp_reg + 64'sh2000_0000_0000;
    assign sy   = pyp_reg + 64'sh2000_0000_0000;
    assign px18 = sx[63:46];
    assign py18 = sy[63:46];

    always_comb begin
        res0      = '0;
        res0_last = 1'b1;
        if (sd.bad) begin
            res0 = '0;
        end else if (!sd.is_tri) begin
            res0.pos_x  = px18[15:0];
            res0.pos_y  = py18[15:0];
            res0.pos_z  = pz_reg;
            res0.norm_x = sat_dbl18(px18);
            res0.norm_y = sat_dbl18(py18);
            res0.norm_z = sat_dbl18(18'(pz_reg));
            res0.tex_u  = sd.tex_u;
            res0.tex_v  = sd.tex_v;
        end else if (sd.first) begin
            // upper triangle of the cell
            res0.corner_a = sd.k1;
            res0.corner_b = sd.k2;
            res0.corner_c = sd.k1 + 13'd1;
            res0_last     = ~sd.second;
        end else begin
            // top stack: only the lower triangle
            res0.corner_a = sd.k1 + 13'd1;
            res0.corner_b = sd.k2;
            res0.corner_c = sd.k2 + 13'd1;
        end
    end

    // pending lower triangle of a two-triangle cell
    always_comb begin
        res1          = '0;
        res1.corner_a = sec_a_reg;
        res1.corner_b = sec_b_reg;
        res1.corner_c = sec_c_reg;
    end

    // side info with the texture coordinates merged in once the dividers are done
    uvsmg_pkg::side_t     side_tex;

    always_comb begin
        side_tex       = side_reg[SP1-1];
        side_tex.tex_u = dse_q_reg[DIV_ST-1][32:17];
        side_tex.tex_v = dst_q_reg[DIV_ST-1][32:17];
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < TOT; s++)
                v_reg[s] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= s_tvalid;
            for (int s = 1; s < TOT; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            ei_reg      <= in_i;
            ej_reg      <= in_j;
            for (int s = 1; s < TOT; s++)
                side_reg[s] <= (s == SP1) ? side_tex : side_reg[s-1];
            for (int k = 0; k < DIV_ST; k++) begin
                dse_rem_reg[k] <= dse_rem_next[k];
                dst_rem_reg[k] <= dst_rem_next[k];
                dse_q_reg[k]   <= dse_q_next[k];
                dst_q_reg[k]   <= dst_q_next[k];
                dj_reg[k]      <= (k == 0) ? ej_reg : dj_reg[(k == 0) ? 0 : k-1];
                di_reg[k]      <= (k == 0) ? ei_reg : di_reg[(k == 0) ? 0 : k-1];
            end
            p1_q_reg[0]   <= sp_st[32:31];
            p1_neg_reg[0] <= sp_st[30];
            p1_mag_reg[0] <= sp_st[29:0];
            p1_q_reg[1]   <= sp_se[32:31];
            p1_neg_reg[1] <= sp_se[30];
            p1_mag_reg[1] <= sp_se[29:0];
            for (int u = 0; u < 2; u++) begin
                p2_q_reg[u]   <= p1_q_reg[u];
                p2_neg_reg[u] <= p1_neg_reg[u];
                p2_z_reg[u]   <= zprod[u][60:30];
                for (int k = 0; k < CS; k++) begin
                    cx_reg[k][u] <= cx_next[k][u];
                    cy_reg[k][u] <= cy_next[k][u];
                    cz_reg[k][u] <= cz_next[k][u];
                    cq_reg[k][u] <= cq_next[k][u];
                end
                qc_reg[u] <= qc_next[u];
                qs_reg[u] <= qs_next[u];
            end
            pxp_reg <= qc_reg[0] * qc_reg[1];
            pyp_reg <= qc_reg[0] * qs_reg[1];
            pz_reg  <= pz_sum[31:16];
        end
    end

    // output register with one pending lower triangle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            has2_reg    <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_reg[SM];
            has2_reg    <= v_reg[SM] & sd.is_tri & ~sd.bad & sd.first & sd.second;
        end else if (m_valid_reg && m_tready) begin
            has2_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= res0;
            m_last_reg <= res0_last;
            sec_a_reg  <= sd.k1 + 13'd1;
            sec_b_reg  <= sd.k2;
            sec_c_reg  <= sd.k2 + 13'd1;
        end else if (m_valid_reg && m_tready) begin
            m_data_reg <= res1;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0,
                       m_data_reg.corner_c, m_data_reg.corner_b, m_data_reg.corner_a,
                       m_data_reg.tex_v, m_data_reg.tex_u,
                       m_data_reg.norm_z, m_data_reg.norm_y, m_data_reg.norm_x,
                       m_data_reg.pos_z, m_data_reg.pos_y, m_data_reg.pos_x};

    // ---------------- assertions ----------------
    `UVSMG_ASSERT_IMP(a_second_needs_valid, aclk, aresetn, has2_reg, m_valid_reg, "pending triangle without valid beat")
    `UVSMG_ASSERT_IMP(a_first_not_last, aclk, aresetn, has2_reg, !m_last_reg, "first of two triangles marked last")
    `UVSMG_ASSERT_IMP(a_stall_blocks_input, aclk, aresetn, m_valid_reg && !m_tready, !s_tready, "input taken while output stalled")
    `UVSMG_ASSERT_NXT(a_second_follows, aclk, aresetn, has2_reg && m_tready, m_valid_reg && m_last_reg && !has2_reg, "second triangle not presented")

endmodule
